// ----- rtl/trle_pkg.sv -----
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the run-length true-color image decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

    // image type code that is decoded
    localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;

    // register indexes on the configuration port
    localparam logic [2:0] REG_IMAGE_TYPE     = 3'd0;
    localparam logic [2:0] REG_PIXEL_BYTES    = 3'd1;
    localparam logic [2:0] REG_ATTRIBUTE_BITS = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd4;

    // packet header fields
    localparam int unsigned HDR_RUN_BIT    = 7;
    localparam logic [6:0]  HDR_COUNT_MASK = 7'h7F;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_TRUNCATED   = 2'd2,
        ST_CLIPPED     = 2'd3
    } status_t;

    // decoder settings seen by the core
    typedef struct packed {
        logic [7:0]  image_type;
        logic [2:0]  pixel_bytes;
        logic [3:0]  attribute_bits;
        logic [31:0] total_pixels;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [31:0] first_index;
        logic        image_done;
        status_t     status;
    } result_t;

endpackage

// ----- rtl/trle_core.sv -----
// ----------------------------------------------------------------------------
// trle_core
// Packet and pixel decoding; one data byte per cycle while take is high, at most one result.
// ----------------------------------------------------------------------------
module trle_core (
    input  logic             clk,
    input  logic             rst_n,
    input  trle_pkg::cfg_t   cfg,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    output logic             res_valid,
    output trle_pkg::result_t res
);
    import trle_pkg::*;

    logic        expect_header_reg, expect_header_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] held_reg, held_next;
    logic [31:0] next_pixel_reg, next_pixel_next;
    logic        finished_reg, finished_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= '0;
            byte_in_pixel_reg <= '0;
            held_reg          <= '0;
            next_pixel_reg    <= '0;
            finished_reg      <= 1'b0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            held_reg          <= held_next;
            next_pixel_reg    <= next_pixel_next;
            finished_reg      <= finished_next;
        end
    end

    always_comb
    begin
        logic [31:0] remaining;
        logic [31:0] left_wide;
        logic [23:0] held_new;
        logic        four;
        logic        last;
        logic        have;
        logic        done;
        logic [7:0]  cnt;
        logic [7:0]  left_after;
        status_t     st;

        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        held_next          = held_reg;
        next_pixel_next    = next_pixel_reg;
        finished_next      = finished_reg;
        res_valid          = 1'b0;
        res                = '0;

        remaining  = cfg.total_pixels - next_pixel_reg;
        left_wide  = {24'd0, packet_left_reg};
        four       = (cfg.pixel_bytes == 3'd4);
        last       = four ? (byte_in_pixel_reg == 2'd3) : (byte_in_pixel_reg >= 2'd2);
        have       = 1'b0;
        done       = 1'b0;
        cnt        = '0;
        left_after = packet_left_reg;
        st         = ST_OK;

        held_new = held_reg;
        unique case (byte_in_pixel_reg)
            2'd0:    held_new = {held_reg[23:8], data_byte};
            2'd1:    held_new = {held_reg[23:16], data_byte, held_reg[7:0]};
            2'd2:    held_new = {data_byte, held_reg[15:0]};
            default: held_new = held_reg;
        endcase

        if (take && !finished_reg)
        begin
            if (cfg.image_type != TYPE_RLE_TRUECOLOR)
            begin
                finished_next   = 1'b1;
                res_valid       = 1'b1;
                res.first_index = next_pixel_reg;
                res.image_done  = 1'b1;
                res.status      = ST_UNSUPPORTED;
            end
            else if (next_pixel_reg >= cfg.total_pixels)
            begin
                // empty or already full image
                finished_next   = 1'b1;
                res_valid       = 1'b1;
                res.first_index = next_pixel_reg;
                res.image_done  = 1'b1;
                res.status      = ST_OK;
            end
            else
            begin
                if (expect_header_reg)
                begin
                    packet_is_run_next = data_byte[HDR_RUN_BIT];
                    packet_left_next   = {1'b0, data_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
                    byte_in_pixel_next = '0;
                    held_next          = '0;
                    expect_header_next = 1'b0;
                end
                else if (last)
                begin
                    have = 1'b1;
                    if (packet_is_run_reg)
                    begin
                        // run cut to the pixels left in the image
                        if (left_wide < remaining)
                            cnt = packet_left_reg;
                        else
                            cnt = remaining[7:0];
                        done       = (left_wide >= remaining);
                        left_after = '0;
                        if (left_wide > remaining)
                            st = ST_CLIPPED;
                    end
                    else
                    begin
                        cnt        = 8'd1;
                        left_after = packet_left_reg - 8'd1;
                        done       = (remaining == 32'd1);
                        if (done && (left_after != 8'd0))
                            st = ST_CLIPPED;
                    end
                    packet_left_next   = left_after;
                    next_pixel_next    = next_pixel_reg + {24'd0, cnt};
                    expect_header_next = (left_after == 8'd0);
                    byte_in_pixel_next = '0;
                    held_next          = '0;
                    if (done)
                        finished_next = 1'b1;

                    res.red          = held_new[23:16];
                    res.green        = held_new[15:8];
                    res.blue         = held_new[7:0];
                    res.alpha        = (four && (cfg.attribute_bits != 4'd0)) ?
                                       data_byte : 8'd0;
                    res.repeat_count = cnt;
                    res.first_index  = next_pixel_reg;
                    res.image_done   = done;
                    res.status       = st;
                end
                else
                begin
                    held_next          = held_new;
                    byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                end

                if (final_byte && !done)
                begin
                    // stream ended before the image filled
                    finished_next  = 1'b1;
                    res_valid      = 1'b1;
                    res.image_done = 1'b1;
                    res.status     = ST_TRUNCATED;
                    if (!have)
                        res.first_index = next_pixel_reg;
                end
                else if (have)
                begin
                    res_valid = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/trle_skid.sv -----
// ----------------------------------------------------------------------------
// trle_skid
// Two-entry result buffer between the decoder and the output channel.
// ----------------------------------------------------------------------------
module trle_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trle_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output trle_pkg::result_t out_data
);
    import trle_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/tga_rle_truecolor_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_truecolor_decoder
// Decodes the pixel-data bytes of a run-length-encoded true-color image.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock while in_stall is low
// and emits each finished pixel, or each whole run, as one R,G,B,A
// transfer with a repeat count and the index of its first pixel. A byte
// is decoded in the cycle it is taken and its result lands in a two-entry
// output buffer, so the input keeps taking one byte every cycle while a
// result waits on a stalled output; in_stall rises only once both buffer
// entries hold results. A result waits in the second entry while the
// output entry is occupied. The pixel total (width times height) is
// multiplied out when width or height is written, so registers must be set
// before the bytes arrive; writes do not restart decoding, only reset does.
// ----------------------------------------------------------------------------
module tga_rle_truecolor_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [7:0]  repeat_count,
    output logic [31:0] first_index,
    output logic        image_done,
    output logic [1:0]  status
);
    import trle_pkg::*;

    // configuration registers
    logic [7:0]  image_type_reg;
    logic [2:0]  pixel_bytes_reg;
    logic [3:0]  attribute_bits_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [31:0] total_reg, total_next;

    logic [2:0]  reg_index;
    logic        cfg_write;

    cfg_t        cfg;
    logic        take;
    logic        res_valid;
    result_t     res;
    logic        buf_full;
    result_t     out_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    // write completes on the access cycle
    assign cfg_write = psel && penable && pwrite;

    // pixel total follows the register write in the same cycle
    always_comb
    begin
        total_next = total_reg;
        if (cfg_write && (reg_index == REG_IMAGE_WIDTH))
            total_next = 32'(pwdata[15:0]) * 32'(image_height_reg);
        else if (cfg_write && (reg_index == REG_IMAGE_HEIGHT))
            total_next = 32'(image_width_reg) * 32'(pwdata[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_type_reg     <= TYPE_RLE_TRUECOLOR;
            pixel_bytes_reg    <= 3'd4;
            attribute_bits_reg <= 4'd8;
            image_width_reg    <= '0;
            image_height_reg   <= '0;
            total_reg          <= '0;
        end
        else
        begin
            total_reg <= total_next;
            if (cfg_write)
            begin
                unique case (reg_index)
                    REG_IMAGE_TYPE:     image_type_reg     <= pwdata[7:0];
                    REG_PIXEL_BYTES:    pixel_bytes_reg    <= pwdata[2:0];
                    REG_ATTRIBUTE_BITS: attribute_bits_reg <= pwdata[3:0];
                    REG_IMAGE_WIDTH:    image_width_reg    <= pwdata[15:0];
                    REG_IMAGE_HEIGHT:   image_height_reg   <= pwdata[15:0];
                    default:            ;
                endcase
            end
        end
    end

    // register read-back
    always_comb
    begin
        unique case (reg_index)
            REG_IMAGE_TYPE:     prdata = {24'd0, image_type_reg};
            REG_PIXEL_BYTES:    prdata = {29'd0, pixel_bytes_reg};
            REG_ATTRIBUTE_BITS: prdata = {28'd0, attribute_bits_reg};
            REG_IMAGE_WIDTH:    prdata = {16'd0, image_width_reg};
            REG_IMAGE_HEIGHT:   prdata = {16'd0, image_height_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.image_type     = image_type_reg;
    assign cfg.pixel_bytes    = pixel_bytes_reg;
    assign cfg.attribute_bits = attribute_bits_reg;
    assign cfg.total_pixels   = total_reg;

    // input transfer
    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    trle_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output buffer keeps the input flowing during output stalls
    trle_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign red          = out_data.red;
    assign green        = out_data.green;
    assign blue         = out_data.blue;
    assign alpha        = out_data.alpha;
    assign repeat_count = out_data.repeat_count;
    assign first_index  = out_data.first_index;
    assign image_done   = out_data.image_done;
    assign status       = out_data.status;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length true-color image decoder.
// ----------------------------------------------------------------------------
// Feeds one long compressed pixel stream into the decoder: a few hand-made
// packets, packets under every pixel format, a burst against a held-off
// result side, then random packets with noise bytes and format changes
// between chunks. Decoding stops for good once it finishes, so each run ends
// the image in one way picked at random (unsupported type, empty image,
// truncated stream, or filled image, mostly with clipping), then checks
// that later bytes are ignored. A cycle-free model of the decoder predicts
// every result transfer, and the checker compares each one field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import trle_pkg::*;

    localparam int HOLD_CYCLES   = 100;        // long hold-off on the result side
    localparam int SETTLE_CYCLES = 4;          // lets a byte with no result settle in wait_idle
    localparam int BYTE_TARGET   = 1950;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef enum int {
        FIN_UNSUPPORTED,
        FIN_EMPTY,
        FIN_TRUNCATED,
        FIN_FILLED
    } finish_kind_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = '0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [31:0] first_index;
    logic        image_done;
    logic [1:0]  status;

    // register copy, as last written through the config port
    logic [7:0]  cfg_type      = TYPE_RLE_TRUECOLOR;
    logic [2:0]  cfg_pix_bytes = 3'd4;
    logic [3:0]  cfg_attr      = 4'd8;
    logic [15:0] cfg_width     = '0;
    logic [15:0] cfg_height    = '0;

    // decode state of the model
    logic        want_header  = 1'b1;
    logic        run_packet   = 1'b0;
    logic [7:0]  pixels_left  = '0;
    logic [1:0]  pix_byte_pos = '0;
    logic [23:0] color_acc    = '0;
    logic [31:0] pixel_pos    = '0;
    logic        decode_over  = 1'b0;

    result_t     pending_pixels[$];    // predicted result transfers, oldest first
    int          mismatches    = 0;
    int          bytes_sent    = 0;    // bytes taken while still decoding
    int          hold_requests = 0;    // bumped to ask the result side for a hold-off
    logic        tx_lazy       = 1'b0;

    tga_rle_truecolor_decoder dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model: one accepted byte in, at most one expected result out
    // ------------------------------------------------------------------------
    function automatic void predict_byte(logic [7:0] d, logic fin);
        logic [31:0] total;
        logic [31:0] remaining;
        int          nbytes;
        logic        alpha_on;
        logic        have_pixel;
        result_t     px;

        total      = 32'(cfg_width) * 32'(cfg_height);
        nbytes     = (cfg_pix_bytes == 3'd4) ? 4 : 3;
        alpha_on   = (cfg_pix_bytes == 3'd4) && (cfg_attr != 4'd0);
        have_pixel = 1'b0;
        px         = '0;

        // once finished, nothing comes out until reset
        if (decode_over)
            return;

        // any other image type ends decoding on the first byte
        if (cfg_type != TYPE_RLE_TRUECOLOR)
        begin
            decode_over    = 1'b1;
            px.first_index = pixel_pos;
            px.image_done  = 1'b1;
            px.status      = ST_UNSUPPORTED;
            pending_pixels.push_back(px);
            return;
        end

        // empty image, or already full after a size change
        if (pixel_pos >= total)
        begin
            decode_over    = 1'b1;
            px.first_index = pixel_pos;
            px.image_done  = 1'b1;
            px.status      = ST_OK;
            pending_pixels.push_back(px);
            return;
        end

        if (want_header)
        begin
            run_packet   = d[HDR_RUN_BIT];
            pixels_left  = {1'b0, d[6:0] & HDR_COUNT_MASK} + 8'd1;
            pix_byte_pos = '0;
            color_acc    = '0;
            want_header  = 1'b0;
        end
        else
        begin
            // bytes come as b, g, r; a fourth byte is alpha
            if (pix_byte_pos < 2'd3)
                color_acc = color_acc | (24'(d) << (8 * pix_byte_pos));
            if (int'(pix_byte_pos) + 1 >= nbytes)
            begin
                remaining      = total - pixel_pos;
                px.blue        = color_acc[7:0];
                px.green       = color_acc[15:8];
                px.red         = color_acc[23:16];
                px.alpha       = alpha_on ? d : 8'd0;
                px.first_index = pixel_pos;
                have_pixel     = 1'b1;
                if (run_packet)
                begin
                    // whole run in one transfer, cut at the image end
                    if (32'(pixels_left) > remaining)
                    begin
                        px.repeat_count = remaining[7:0];
                        px.status       = ST_CLIPPED;
                    end
                    else
                    begin
                        px.repeat_count = pixels_left;
                    end
                    pixels_left = '0;
                end
                else
                begin
                    px.repeat_count = 8'd1;
                    pixels_left     = pixels_left - 8'd1;
                end
                pixel_pos = pixel_pos + 32'(px.repeat_count);
                if (pixel_pos >= total)
                begin
                    px.image_done = 1'b1;
                    decode_over   = 1'b1;
                    // raw packet with pixels still unread
                    if (pixels_left != 8'd0)
                        px.status = ST_CLIPPED;
                end
                if (pixels_left == 8'd0)
                    want_header = 1'b1;
                pix_byte_pos = '0;
                color_acc    = '0;
            end
            else
            begin
                pix_byte_pos = pix_byte_pos + 2'd1;
            end
        end

        // last byte of the file while the image is still short
        if (fin && !decode_over)
        begin
            decode_over = 1'b1;
            if (!have_pixel)
                px.first_index = pixel_pos;
            px.image_done = 1'b1;
            px.status     = ST_TRUNCATED;
            pending_pixels.push_back(px);
        end
        else if (have_pixel)
        begin
            pending_pixels.push_back(px);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_pixel();
        result_t want;
        if (pending_pixels.size() == 0)
        begin
            $display("%0t: result transfer with nothing expected, got rgba %h %h %h %h",
                     $time, red, green, blue, alpha);
            $display("%0t:   count %0d index %0d done %b status %0d",
                     $time, repeat_count, first_index, image_done, status);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        check_field("red", want.red, red);
        check_field("green", want.green, green);
        check_field("blue", want.blue, blue);
        check_field("alpha", want.alpha, alpha);
        check_field("repeat_count", want.repeat_count, repeat_count);
        check_field("first_index", want.first_index, first_index);
        check_field("image_done", want.image_done, image_done);
        check_field("status", want.status, status);
    endfunction

    // result side: stalls drawn per transfer, plus long hold-offs on request
    initial
    begin : result_side
        int   wait_left;
        int   hold_left;
        int   holds_served;
        logic rx_lazy;
        wait_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        rx_lazy      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_pixel();
                // switch between stall-free stretches and random stalls
                if ($urandom_range(0, 49) == 0)
                    rx_lazy = !rx_lazy;
                wait_left = rx_lazy ? $urandom_range(0, 8) : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers; every task starts and returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        // access phase
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_IMAGE_TYPE:     cfg_type      = value[7:0];
            REG_PIXEL_BYTES:    cfg_pix_bytes = value[2:0];
            REG_ATTRIBUTE_BITS: cfg_attr      = value[3:0];
            REG_IMAGE_WIDTH:    cfg_width     = value[15:0];
            REG_IMAGE_HEIGHT:   cfg_height    = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_lazy = !tx_lazy;
        gap = tx_lazy ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        // payload holds until the transfer
        do
            @(posedge clk);
        while (in_stall);
        if (!decode_over)
            bytes_sent++;
        predict_byte(b, fin);
        @(negedge clk);
    endtask

    // all results in, then a settling wait for a byte with no result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one whole packet laid out for the current pixel size
    task automatic send_packet();
        logic       run;
        logic [6:0] count;
        int         nbytes;
        int         pixels;
        run    = 1'($urandom_range(0, 1));
        nbytes = (cfg_pix_bytes == 3'd4) ? 4 : 3;
        if (run)
        begin
            case ($urandom_range(0, 7))
                0:       count = HDR_COUNT_MASK;
                1, 2:    count = 7'($urandom_range(8, 126));
                default: count = 7'($urandom_range(0, 7));
            endcase
        end
        else
        begin
            // long raw packets cost hundreds of bytes, keep them rare
            count = ($urandom_range(0, 59) == 0) ? HDR_COUNT_MASK : 7'($urandom_range(0, 15));
        end
        send_byte({run, count}, 1'b0);
        pixels = run ? 1 : int'(count) + 1;
        repeat (pixels * nbytes) send_byte(pick_byte(), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_packets();
        logic [7:0] opening [24] = '{
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00,                       // raw, one pixel
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,                       // run of 128
            8'h80, 8'h12, 8'h34, 8'h56, 8'h78,                       // run of 1
            8'h01, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'h0F, 8'h1E, 8'h2D, 8'h3C  // raw, two
        };
        write_reg(REG_IMAGE_TYPE, TYPE_RLE_TRUECOLOR);
        write_reg(REG_PIXEL_BYTES, 4);
        write_reg(REG_ATTRIBUTE_BITS, 8);
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        foreach (opening[i])
            send_byte(opening[i], 1'b0);
    endtask

    task automatic test_pixel_formats();
        logic [2:0] fmt_bytes [5] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd4};
        logic [3:0] fmt_attr  [5] = '{4'd0, 4'd0, 4'd15, 4'd15, 4'd1};
        int         phase_end;
        foreach (fmt_bytes[i])
        begin
            wait_idle();
            write_reg(REG_PIXEL_BYTES, fmt_bytes[i]);
            write_reg(REG_ATTRIBUTE_BITS, fmt_attr[i]);
            phase_end = bytes_sent + 40;
            while (bytes_sent < phase_end)
                send_packet();
        end
    endtask

    // result side holds off while bytes keep coming, so the input must stall
    task automatic test_output_backpressure();
        int nbytes;
        wait_idle();
        nbytes = (cfg_pix_bytes == 3'd4) ? 4 : 3;
        hold_requests++;
        send_byte(8'h0F, 1'b0);            // raw, sixteen pixels
        repeat (16 * nbytes) send_byte(pick_byte(), 1'b0);
    endtask

    task automatic test_random_stream();
        int chunk_end;
        while (bytes_sent < BYTE_TARGET - 60)
        begin
            chunk_end = bytes_sent + $urandom_range(60, 240);
            if ($urandom_range(0, 4) == 0)
                hold_requests++;
            while (bytes_sent < chunk_end)
            begin
                // stray bytes knock packets out of step now and then
                if ($urandom_range(0, 11) == 0)
                    repeat ($urandom_range(1, 6)) send_byte(pick_byte(), 1'b0);
                else
                    send_packet();
            end
            wait_idle();
            write_reg(REG_PIXEL_BYTES, $urandom_range(3, 4));
            write_reg(REG_ATTRIBUTE_BITS, $urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
            begin
                // size stays far beyond the pixels written so far
                write_reg(REG_IMAGE_WIDTH, $urandom_range(4096, 65535));
                write_reg(REG_IMAGE_TYPE, TYPE_RLE_TRUECOLOR);
            end
        end
    endtask

    // decoding can end only once per reset, so one ending is drawn per run
    task automatic test_image_end();
        finish_kind_t how;
        logic [31:0]  target;
        logic [31:0]  span;
        how = finish_kind_t'($urandom_range(0, 3));
        wait_idle();
        case (how)
            FIN_UNSUPPORTED:
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_IMAGE_TYPE, 8'h00);
                    1:       write_reg(REG_IMAGE_TYPE, 8'hFF);
                    2:       write_reg(REG_IMAGE_TYPE, TYPE_RLE_TRUECOLOR - 8'd1);
                    default: write_reg(REG_IMAGE_TYPE, TYPE_RLE_TRUECOLOR + 8'd1);
                endcase
                send_packet();
            end
            FIN_EMPTY:
            begin
                // either a zero size or a size the image already fills
                if (pixel_pos <= 32'hFFFF && $urandom_range(0, 1) == 1)
                begin
                    write_reg(REG_IMAGE_WIDTH, 1);
                    write_reg(REG_IMAGE_HEIGHT, pixel_pos);
                end
                else
                begin
                    write_reg($urandom_range(0, 1) ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT, 0);
                end
                send_packet();
            end
            FIN_TRUNCATED:
            begin
                repeat ($urandom_range(0, 3)) send_packet();
                repeat ($urandom_range(0, 6)) send_byte(pick_byte(), 1'b0);
                send_byte(pick_byte(), 1'b1);
            end
            default:
            begin
                // a few pixels left, so most endings clip a packet
                target = pixel_pos + $urandom_range(1, 40);
                span   = target / 32'd65535 + 32'd1;
                write_reg(REG_IMAGE_WIDTH, span);
                write_reg(REG_IMAGE_HEIGHT, target / span + 32'd1);
                while (!decode_over)
                    send_packet();
            end
        endcase
    endtask

    // settings that would decode again, yet every byte must be ignored
    task automatic test_after_finish();
        wait_idle();
        write_reg(REG_IMAGE_TYPE, 8'h00);
        write_reg(REG_IMAGE_TYPE, 8'hFF);
        write_reg(REG_PIXEL_BYTES, 3);
        write_reg(REG_ATTRIBUTE_BITS, 0);
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_IMAGE_TYPE, TYPE_RLE_TRUECOLOR);
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (8) send_byte(pick_byte(), 1'($urandom_range(0, 1)));
        send_byte(pick_byte(), 1'b1);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_packets();
        test_pixel_formats();
        test_output_backpressure();
        test_random_stream();
        test_image_end();
        test_after_finish();
        wait_idle();
        if (mismatches == 0)
            $display("PASS tga_rle_truecolor_decoder");
        else
            $display("FAIL tga_rle_truecolor_decoder");
        $finish;
    end

    // hung handshake or a result that never comes
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL tga_rle_truecolor_decoder");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/trle_pkg.sv
rtl/trle_core.sv
rtl/trle_skid.sv
rtl/tga_rle_truecolor_decoder.sv
bench/tb_top.sv
